### rtl/fqs_pkg.sv
// Shared codes and types for the queue with search.
// No dependencies; imported by the cells and the top level.
`default_nettype none

package fqs_pkg;

	localparam logic [1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [1:0] ACT_DEQUEUE = 2'd1;
	localparam logic [1:0] ACT_SEARCH  = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// search token that walks the chain, one cell per cycle
	typedef struct packed {
		logic vld;
		logic hit;
	} srch_t;

	// per-cell control from the queue controller
	typedef struct packed {
		logic load;
		logic shift;
		logic held;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/fqs_in_if.sv
// Input channel: action and value with valid/ready handshake.
// No dependencies.
`default_nettype none

interface fqs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

### rtl/fqs_out_if.sv
// Result channel: status, dequeued data, search hit and fill level.
// No dependencies.
`default_nettype none

interface fqs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] data_out;
	logic        found;
	logic        is_empty;
	logic [4:0]  occupancy;

	modport source (output valid, output status, output data_out, output found,
		output is_empty, output occupancy, input ready);
	modport sink   (input valid, input status, input data_out, input found,
		input is_empty, input occupancy, output ready);
endinterface

`default_nettype wire

### rtl/fifo_queue_with_search.sv
// Queue of DEPTH items built as a chain of shifting cells, with a search
// token that walks the chain. Depends on fqs_pkg, fqs_in_if, fqs_out_if, fqs_cell.
//
//  channel | role | payload
//  req     | sink | action[1:0], value[31:0]
//  rsp     | src  | status[1:0], data_out[31:0], found, is_empty, occupancy[4:0]
//
// An enqueue writes the entry into the cell at the fill level, and a dequeue
// shifts every cell one place toward the head.
// A search launches the token, which steps down the chain through each cell's
// register; the hit is then latched and loaded into the result register.
// Reset empties the queue at once; cell contents are not cleared.
// A stalled result holds in the output register; req.ready stays low until it drains.
`default_nettype none

module fifo_queue_with_search import fqs_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int ITEM_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	fqs_in_if.sink   req,
	fqs_out_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EMIT} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         cnt_nxt;
	logic [ITEM_WIDTH-1:0] key_q;
	logic                  start_q;
	logic                  hit_q;
	logic                  out_vld_q;
	logic [1:0]            status_q;
	logic [31:0]           data_q;
	logic                  found_q;
	logic                  empty_q;
	logic [4:0]            occ_q;

	logic                     in_fire;
	logic                     full;
	logic                     empty;
	logic                     enq_go;
	logic                     deq_go;
	logic                     out_free;
	logic [ITEM_WIDTH+31:0]   item_wide;
	logic [ITEM_WIDTH-1:0]    item;
	logic [ITEM_WIDTH+31:0]   head_wide;
	logic [CW+4:0]            occ_nxt_wide;
	logic [CW+4:0]            occ_cur_wide;

	logic [ITEM_WIDTH-1:0] ent [DEPTH];
	srch_t                 chain [DEPTH+1];

	assign out_free  = ~out_vld_q | rsp.ready;
	assign req.ready = (state_q == S_IDLE) & out_free;
	assign in_fire   = req.valid & req.ready;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign enq_go = in_fire & (req.action == ACT_ENQUEUE) & ~full;
	assign deq_go = in_fire & (req.action == ACT_DEQUEUE) & ~empty;

	always_comb begin
		cnt_nxt = count_q;
		if (enq_go) begin
			cnt_nxt = count_q + CW'(1);
		end else if (deq_go) begin
			cnt_nxt = count_q - CW'(1);
		end
	end

	assign item_wide    = {{ITEM_WIDTH{1'b0}}, req.value};
	assign item         = item_wide[ITEM_WIDTH-1:0];
	assign head_wide    = {32'd0, ent[0]};
	assign occ_nxt_wide = {5'd0, cnt_nxt};
	assign occ_cur_wide = {5'd0, count_q};

	assign chain[0] = '{vld: start_q, hit: 1'b0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t             ctl;
		logic [ITEM_WIDTH-1:0] nxt;

		assign ctl.load  = enq_go & (count_q == CW'(i));
		assign ctl.shift = deq_go;
		assign ctl.held  = (CW'(i) < count_q);

		if (i == DEPTH - 1) begin : g_tail
			assign nxt = ent[i];
		end else begin : g_body
			assign nxt = ent[i+1];
		end

		fqs_cell #(
			.ITEM_WIDTH(ITEM_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.din    (item),
			.nxt    (nxt),
			.key    (key_q),
			.srch_i (chain[i]),
			.entry  (ent[i]),
			.srch_o (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			key_q     <= '0;
			start_q   <= 1'b0;
			hit_q     <= 1'b0;
			out_vld_q <= 1'b0;
			status_q  <= ST_DONE;
			data_q    <= '0;
			found_q   <= 1'b0;
			empty_q   <= 1'b1;
			occ_q     <= '0;
		end else begin
			start_q   <= 1'b0;
			out_vld_q <= out_vld_q & ~rsp.ready;
			count_q   <= cnt_nxt;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						out_vld_q <= 1'b1;
						status_q  <= ST_DONE;
						data_q    <= '0;
						found_q   <= 1'b0;
						empty_q   <= (cnt_nxt == '0);
						occ_q     <= occ_nxt_wide[4:0];
						unique case (req.action)
							ACT_ENQUEUE: begin
								if (full) begin
									status_q <= ST_FULL;
								end
							end
							ACT_DEQUEUE: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									data_q <= head_wide[31:0];
								end
							end
							ACT_SEARCH: begin
								out_vld_q <= 1'b0;
								key_q     <= item;
								start_q   <= 1'b1;
								state_q   <= S_SEARCH;
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (chain[DEPTH].vld) begin
						hit_q   <= chain[DEPTH].hit;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						status_q  <= ST_DONE;
						data_q    <= '0;
						found_q   <= hit_q;
						empty_q   <= empty;
						occ_q     <= occ_cur_wide[4:0];
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.status    = status_q;
	assign rsp.data_out  = data_q;
	assign rsp.found     = found_q;
	assign rsp.is_empty  = empty_q;
	assign rsp.occupancy = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill level beyond depth");

	a_tail_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		chain[DEPTH].vld |-> (state_q == S_SEARCH))
		else $error("search token left the chain outside a search");

	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count_q))
		else $error("fill level moved during a search");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (status_q == ST_EMPTY)) |-> (empty_q && (occ_q == 5'd0) && (data_q == '0)))
		else $error("empty dequeue result inconsistent");

endmodule

`default_nettype wire

### rtl/fqs_cell.sv
// One storage cell of the queue: holds an entry, shifts toward the head,
// and compares a passing search token. Depends on fqs_pkg.
`default_nettype none

module fqs_cell import fqs_pkg::*; #(
	parameter int ITEM_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic [ITEM_WIDTH-1:0] din,
	input  wire logic [ITEM_WIDTH-1:0] nxt,
	input  wire logic [ITEM_WIDTH-1:0] key,
	input  wire srch_t                 srch_i,
	output logic      [ITEM_WIDTH-1:0] entry,
	output srch_t                      srch_o
);

	logic [ITEM_WIDTH-1:0] entry_q;
	srch_t                 srch_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= din;
		end else if (ctl.shift) begin
			entry_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_q <= '0;
		end else begin
			srch_q.vld <= srch_i.vld;
			srch_q.hit <= srch_i.hit | (srch_i.vld & ctl.held & (entry_q == key));
		end
	end

	assign entry  = entry_q;
	assign srch_o = srch_q;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for fifo_queue_with_search: random valid/ready pacing on both
// channels, a scoreboard class that tracks the queue contents and checks each result.
// Depends on fqs_pkg, fqs_in_if, fqs_out_if and the fifo_queue_with_search RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fqs_pkg::*;

	localparam int DEPTH = 16;
	localparam int PHASE_ITEMS = 235;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] ACT_NOP = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data_out;
		logic        found;
		logic        is_empty;
		logic [4:0]  occupancy;
	} outcome_t;

	class fqs_scoreboard;
		logic [31:0] slots [DEPTH];
		int          head;
		int          tail;
		int          fill;
		int          errors;
		outcome_t    pending_q [$];

		function new();
			head = 0;
			tail = 0;
			fill = 0;
			errors = 0;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function logic [31:0] pick_held();
			if (fill == 0)
				return $urandom;
			return slots[(head + $urandom_range(0, fill - 1)) % DEPTH];
		endfunction

		function void note_request(logic [1:0] act, logic [31:0] val);
			outcome_t o;
			o = '0;
			o.status = ST_DONE;
			case (act)
				ACT_ENQUEUE: begin
					if (fill >= DEPTH) begin
						o.status = ST_FULL;
					end else begin
						slots[tail] = val;
						tail = (tail + 1) % DEPTH;
						fill++;
					end
				end
				ACT_DEQUEUE: begin
					if (fill == 0) begin
						o.status = ST_EMPTY;
					end else begin
						o.data_out = slots[head];
						head = (head + 1) % DEPTH;
						fill--;
					end
				end
				ACT_SEARCH: begin
					for (int k = 0; k < fill; k++)
						if (slots[(head + k) % DEPTH] == val)
							o.found = 1'b1;
				end
				default: ;
			endcase
			o.is_empty = (fill == 0);
			o.occupancy = fill[4:0];
			pending_q.push_back(o);
		endfunction

		function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
			if (got !== exp) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, got);
				errors++;
			end
		endfunction

		function void check_result(outcome_t got);
			outcome_t exp;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0h", $time, got);
				errors++;
				return;
			end
			exp = pending_q.pop_front();
			compare_field("status", 32'(exp.status), 32'(got.status));
			compare_field("data_out", exp.data_out, got.data_out);
			compare_field("found", 32'(exp.found), 32'(got.found));
			compare_field("is_empty", 32'(exp.is_empty), 32'(got.is_empty));
			compare_field("occupancy", 32'(exp.occupancy), 32'(got.occupancy));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   cycles = 0;

	fqs_scoreboard sb = new();

	fqs_in_if  req_if();
	fqs_out_if rsp_if();

	fifo_queue_with_search #(
		.DEPTH(DEPTH),
		.ITEM_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.status = rsp_if.status;
			got.data_out = rsp_if.data_out;
			got.found = rsp_if.found;
			got.is_empty = rsp_if.is_empty;
			got.occupancy = rsp_if.occupancy;
			sb.check_result(got);
		end
	end

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	task automatic send_request(input logic [1:0] act, input logic [31:0] val);
		while ($urandom_range(0, 99) < send_idle) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= act;
		req_if.value <= val;
		do
			@(posedge clk);
		while (!req_if.ready);
		sb.note_request(act, val);
		@(negedge clk);
	endtask

	task automatic run_directed();
		send_request(ACT_DEQUEUE, 32'hFFFF_FFFF);
		send_request(ACT_SEARCH, 32'h0000_0000);
		send_request(ACT_NOP, 32'hFFFF_FFFF);
		send_request(ACT_ENQUEUE, 32'h0000_0000);
		send_request(ACT_ENQUEUE, 32'hFFFF_FFFF);
		send_request(ACT_SEARCH, 32'h0000_0000);
		send_request(ACT_SEARCH, 32'hFFFF_FFFF);
		send_request(ACT_SEARCH, 32'h0001_2345);
		// fill up with walking patterns
		for (int i = 0; i < DEPTH - 2; i++)
			send_request(ACT_ENQUEUE, (32'h1 << (2 * i)) | (32'h8000_0000 >> i));
		send_request(ACT_ENQUEUE, 32'hA5A5_A5A5);
		send_request(ACT_NOP, 32'h0000_0000);
		send_request(ACT_DEQUEUE, 32'h0000_0000);
	endtask

	task automatic run_random(input int count);
		int          enq_bias;
		int          r;
		logic [1:0]  act;
		logic [31:0] val;
		enq_bias = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 32 == 0) begin
				case ($urandom_range(0, 2))
					0: enq_bias = 15;
					1: enq_bias = 50;
					default: enq_bias = 85;
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 4)
				act = ACT_NOP;
			else if (r < 30)
				act = ACT_SEARCH;
			else if ($urandom_range(0, 99) < enq_bias)
				act = ACT_ENQUEUE;
			else
				act = ACT_DEQUEUE;
			case ($urandom_range(0, 3))
				0: val = sb.pick_held();
				1: val = $urandom_range(0, 7);
				default: val = $urandom;
			endcase
			send_request(act, val);
		end
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.action = ACT_ENQUEUE;
		req_if.value = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle = 10;
		recv_idle = 67;
		run_directed();
		run_random(PHASE_ITEMS);

		send_idle = 67;
		recv_idle = 10;
		run_random(PHASE_ITEMS);

		send_idle = 0;
		recv_idle = 0;
		run_random(PHASE_ITEMS);

		req_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
